// ----- rtl/core/sida_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sida_pkg
// Shared constants and types for the signed integer to decimal ASCII block.
// ----------------------------------------------------------------------------
package sida_pkg;

    // Width of the converted two's complement value (range 8..64).
    localparam int VALUE_BITS = 32;
    // Width of the input value field.
    localparam int IN_BITS    = 32;
    // Decimal digits needed for 2^(VALUE_BITS-1); 1233/4096 ~ log10(2).
    localparam int DIGITS     = ((VALUE_BITS * 1233) >> 12) + 1;
    localparam int BCD_BITS   = DIGITS * 4;
    localparam int BIT_CNT_W  = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
    localparam int DIG_CNT_W  = $clog2(DIGITS + 1);

    localparam logic [7:0] ASCII_ZERO  = 8'd48;
    localparam logic [7:0] ASCII_MINUS = 8'd45;

    // Converted number handed from the converter to the character emitter.
    typedef struct packed {
        logic                neg;
        logic [BCD_BITS-1:0] bcd;
    } sida_conv_t;

endpackage

// ----- rtl/core/sida_dabble.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sida_dabble
// Bit-serial binary to BCD converter (shift and add-3), one bit per cycle.
// ----------------------------------------------------------------------------
module sida_dabble (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              in_neg,
    input  logic [sida_pkg::VALUE_BITS-1:0]   in_mag,
    output logic                              out_valid,
    input  logic                              out_ready,
    output sida_pkg::sida_conv_t              out_conv
);
    import sida_pkg::*;

    logic [VALUE_BITS-1:0] bin_reg, bin_next;
    logic [BCD_BITS-1:0]   bcd_reg, bcd_next;
    logic [BCD_BITS-1:0]   bcd_adj;
    logic [BIT_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                  neg_reg, neg_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int d = 0; d < DIGITS; d++) begin
            if (bcd_reg[d*4 +: 4] >= 4'd5) begin
                bcd_adj[d*4 +: 4] = bcd_reg[d*4 +: 4] + 4'd3;
            end else begin
                bcd_adj[d*4 +: 4] = bcd_reg[d*4 +: 4];
            end
        end
    end

    assign in_ready     = !busy_reg && !done_reg;
    assign out_valid    = done_reg;
    assign out_conv.neg = neg_reg;
    assign out_conv.bcd = bcd_reg;

    always_comb begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (done_reg && out_ready) begin
            done_next = 1'b0;
        end
        if (in_valid && in_ready) begin
            bin_next  = in_mag;
            bcd_next  = '0;
            cnt_next  = BIT_CNT_W'(VALUE_BITS - 1);
            neg_next  = in_neg;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            bcd_next = {bcd_adj[BCD_BITS-2:0], bin_reg[VALUE_BITS-1]};
            bin_next = bin_reg << 1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
    end

endmodule

// ----- rtl/core/sida_emit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sida_emit
// Shifts BCD digits out most significant first as ASCII, after a '-' for a
// negative number, skipping leading zeros, behind a registered output stage.
// ----------------------------------------------------------------------------
module sida_emit (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  ld_valid,
    output logic                  ld_ready,
    input  sida_pkg::sida_conv_t  ld_conv,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_character,
    output logic                  m_last
);
    import sida_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SIGN,
        ST_SKIP,
        ST_EMIT
    } state_t;

    state_t                state_reg, state_next;
    logic [BCD_BITS-1:0]   bcd_reg, bcd_next;
    logic [DIG_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                  m_valid_reg, m_valid_next;
    logic [7:0]            m_character_reg, m_character_next;
    logic                  m_last_reg, m_last_next;
    logic                  out_free;
    logic [3:0]            top_digit;
    logic                  cnt_one;

    assign top_digit   = bcd_reg[BCD_BITS-1 -: 4];
    assign cnt_one     = (cnt_reg == DIG_CNT_W'(1));
    assign out_free    = !m_valid_reg || m_ready;
    assign ld_ready    = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_character = m_character_reg;
    assign m_last      = m_last_reg;

    always_comb begin
        state_next       = state_reg;
        bcd_next         = bcd_reg;
        cnt_next         = cnt_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_character_next = m_character_reg;
        m_last_next      = m_last_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (ld_valid) begin
                    bcd_next   = ld_conv.bcd;
                    cnt_next   = DIG_CNT_W'(DIGITS);
                    state_next = ld_conv.neg ? ST_SIGN : ST_SKIP;
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_character_next = ASCII_MINUS;
                    m_last_next      = 1'b0;
                    state_next       = ST_SKIP;
                end
            end
            ST_SKIP: begin
                // drop leading zeros, but always keep the ones digit
                if (top_digit == 4'd0 && !cnt_one) begin
                    bcd_next = bcd_reg << 4;
                    cnt_next = cnt_reg - 1'b1;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_character_next = ASCII_ZERO + {4'd0, top_digit};
                    m_last_next      = cnt_one;
                    bcd_next         = bcd_reg << 4;
                    cnt_next         = cnt_reg - 1'b1;
                    if (cnt_one) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        bcd_reg         <= bcd_next;
        cnt_reg         <= cnt_next;
        m_character_reg <= m_character_next;
        m_last_reg      <= m_last_next;
    end

endmodule

// ----- rtl/core/signed_int_to_decimal_ascii.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a two's complement integer to decimal ASCII text, one character
// per result request.
// ----------------------------------------------------------------------------
// Usage:
//   s_value (valid/ready) takes one integer; its low VALUE_BITS bits are the
//   number. m_character/m_last (valid/ready) return its text: '-' for a
//   negative value, then digits most significant first without leading
//   zeros; zero gives a single '0'. m_last marks the final character.
//   The magnitude is shifted through a BCD converter one bit per cycle,
//   then leading zeros are dropped one digit per cycle. The converter
//   takes a new number once it has handed the last one to the emitter,
//   so the next number converts while the previous one's characters are
//   still leaving.
//   Reset (aresetn low, synchronous) drops any number in flight and clears
//   m_valid. When the receiver stalls, the current character is held in the
//   output register and the pipeline stops behind it.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [sida_pkg::IN_BITS-1:0] s_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [7:0]                        m_character,
    output logic                              m_last
);
    import sida_pkg::*;

    logic [VALUE_BITS-1:0] raw;
    logic [VALUE_BITS-1:0] mag;
    logic                  neg;
    logic                  conv_valid;
    logic                  conv_ready;
    sida_conv_t            conv;

    assign raw = VALUE_BITS'(s_value);
    assign neg = raw[VALUE_BITS-1];
    // unsigned negate: the most negative value keeps its full magnitude
    assign mag = neg ? (~raw + 1'b1) : raw;

    sida_dabble u_dabble (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_neg    (neg),
        .in_mag    (mag),
        .out_valid (conv_valid),
        .out_ready (conv_ready),
        .out_conv  (conv)
    );

    sida_emit u_emit (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ld_valid    (conv_valid),
        .ld_ready    (conv_ready),
        .ld_conv     (conv),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_character (m_character),
        .m_last      (m_last)
    );

endmodule

// ----- rtl/core/sida_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sida_checker
// Port-level checks for signed_int_to_decimal_ascii.
// ----------------------------------------------------------------------------
module sida_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_character,
    input logic       m_last
);
    import sida_pkg::*;

    // nothing leaves in the cycle after reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // a stalled character holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_character) && $stable(m_last))
        else $error("stalled character changed");

    // only a minus sign or a decimal digit is ever sent
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_character == ASCII_MINUS) ||
                    (m_character >= ASCII_ZERO && m_character <= ASCII_ZERO + 8'd9))
        else $error("bad character code");

    // the sign is never the final character
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_character == ASCII_MINUS |-> !m_last)
        else $error("minus sign flagged last");

    // converter is busy for the cycle after taking a request
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after accept");

endmodule

bind signed_int_to_decimal_ascii sida_checker u_sida_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_character (m_character),
    .m_last      (m_last)
);

// ----- tb/tb_signed_int_to_decimal_ascii.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_signed_int_to_decimal_ascii
// Self-checking bench for the integer to decimal ASCII converter. Each value
// sent is turned into its expected character string by a local predictor;
// every character request leaving the block is checked against the oldest
// expected character and its last flag. Covers extremes, many digit counts,
// a long output stall that backs up the input, and random values with random
// idling on both sides.
// ----------------------------------------------------------------------------
module tb_signed_int_to_decimal_ascii;
    import sida_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int IDLE_PCT       = 23;
    localparam int MAX_PRINTED    = 40;

    typedef struct {
        logic [7:0] ch;
        logic       last_flag;
    } text_char_t;

    logic                       aclk    = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic signed [IN_BITS-1:0]  s_value = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [7:0]                 m_character;
    logic                       m_last;

    text_char_t text_q[$];
    int         mismatches = 0;
    int         stall_cycles = 0;
    int         hold_req = 0;
    int         hold_left = 0;
    bit         idle_on = 1'b1;

    signed_int_to_decimal_ascii u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_character (m_character),
        .m_last      (m_last)
    );

    always #5 aclk = ~aclk;

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTED)
            $display("ERROR @%0t: %s", $time, msg);
        mismatches++;
    endtask

    // Queue the decimal text of one accepted value.
    function automatic void predict_decimal_text(input logic [IN_BITS-1:0] v);
        logic [63:0] mask;
        logic [63:0] raw;
        logic [63:0] mag;
        logic        neg;
        logic [3:0]  digit_q[$];
        text_char_t  c;
        mask = (VALUE_BITS >= 64) ? '1 : ((64'd1 << VALUE_BITS) - 64'd1);
        raw  = 64'(v) & mask;
        neg  = raw[VALUE_BITS-1];
        // magnitude as unsigned, so the most negative value does not overflow
        mag  = neg ? ((64'd0 - raw) & mask) : raw;
        do begin
            digit_q.push_front(4'(mag % 64'd10));
            mag = mag / 64'd10;
        end while (mag != 0);
        if (neg) begin
            c.ch        = ASCII_MINUS;
            c.last_flag = 1'b0;
            text_q.push_back(c);
        end
        foreach (digit_q[i]) begin
            c.ch        = ASCII_ZERO + 8'(digit_q[i]);
            c.last_flag = (i == digit_q.size() - 1);
            text_q.push_back(c);
        end
    endfunction

    // Offer one value; returns at the edge where it is accepted with valid
    // still high, so a following request can go out back to back.
    task automatic send_value(input logic [IN_BITS-1:0] v);
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_decimal_text(v);
    endtask

    function automatic logic [IN_BITS-1:0] pow10(input int k);
        logic [63:0] p;
        p = 64'd1;
        repeat (k) p = p * 64'd10;
        return IN_BITS'(p);
    endfunction

    function automatic logic [IN_BITS-1:0] random_value();
        logic [63:0]        wide;
        logic [IN_BITS-1:0] v;
        int                 w;
        wide = {$urandom, $urandom};
        case ($urandom_range(3))
            0: v = IN_BITS'(wide);
            1: v = IN_BITS'($urandom_range(999));
            2: v = pow10($urandom_range(9)) + IN_BITS'($urandom_range(2)) - IN_BITS'(1);
            default: begin
                w = $urandom_range(IN_BITS);
                v = IN_BITS'(wide & ((64'd1 << w) - 64'd1));
            end
        endcase
        if ($urandom_range(1))
            v = -v;
        return v;
    endfunction

    // Receiver: random ready, with an optional long hold-off counted here.
    always @(posedge aclk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (idle_on) begin
            m_ready <= ($urandom_range(99) >= IDLE_PCT);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : check_text
        text_char_t want;
        if (aresetn && m_valid && m_ready) begin
            if (text_q.size() == 0) begin
                report_mismatch($sformatf("unexpected character 0x%02h last=%0b",
                                          m_character, m_last));
            end else begin
                want = text_q.pop_front();
                if (m_character !== want.ch)
                    report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                              m_character, want.ch));
                if (m_last !== want.last_flag)
                    report_mismatch($sformatf("last %0b, expected %0b on char 0x%02h",
                                              m_last, want.last_flag, want.ch));
            end
        end
    end

    // Watchdog: cycles with no request accepted on either side.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic test_extremes();
        send_value('0);
        send_value(IN_BITS'(1));
        send_value('1);
        send_value({1'b0, {(IN_BITS-1){1'b1}}});
        send_value({1'b1, {(IN_BITS-1){1'b0}}});
        send_value({1'b1, {(IN_BITS-2){1'b0}}, 1'b1});
        send_value(IN_BITS'(1234567890));
        send_value(-IN_BITS'(987654321));
    endtask

    // One value per power of ten 10^1..10^9, alternating sign and the 10^k / 10^k-1 edge.
    task automatic test_digit_counts();
        for (int k = 1; k <= 9; k++) begin
            if (k % 2)
                send_value(-pow10(k));
            else
                send_value(pow10(k) - IN_BITS'(1));
        end
    endtask

    // Hold the output long enough that the block backs up its input.
    task automatic test_output_stall();
        hold_req = 400;
        repeat (20) send_value(random_value());
    endtask

    task automatic test_random_values();
        idle_on = 1'b1;
        repeat (130) send_value(random_value());
        idle_on = 1'b0;
        repeat (80) send_value(random_value());
        idle_on = 1'b1;
        repeat (135) send_value(random_value());
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_extremes();
        test_digit_counts();
        test_output_stall();
        test_random_values();

        s_valid <= 1'b0;
        while (text_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0 && text_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
